[design/qvr_pkg.sv]
// Shared widths, payload types and lane types for the quaternion vector rotator.
package qvr_pkg;

   // Field widths and fixed-point format
   localparam int QUAT_BITS = 16;
   localparam int VEC_BITS  = 24;
   localparam int FRAC_BITS = QUAT_BITS - 2;
   localparam int SHIFT     = 2 * FRAC_BITS;

   // Internal word widths: pairwise product, matrix entry, lane term, lane sum
   localparam int PROD_BITS = 2 * QUAT_BITS;
   localparam int COEF_BITS = PROD_BITS + 2;
   localparam int TERM_BITS = COEF_BITS + VEC_BITS;
   localparam int SUM_BITS  = TERM_BITS + 2;
   localparam int RES_BITS  = SUM_BITS - SHIFT;

   // One lane per matrix row, three vector parts
   localparam int LANES   = 3;
   localparam int AXES    = 3;
   localparam int LATENCY = 6;

   typedef struct packed {
      logic signed [QUAT_BITS-1:0] q_w;
      logic signed [QUAT_BITS-1:0] q_x;
      logic signed [QUAT_BITS-1:0] q_y;
      logic signed [QUAT_BITS-1:0] q_z;
      logic signed [VEC_BITS-1:0]  vec_x;
      logic signed [VEC_BITS-1:0]  vec_y;
      logic signed [VEC_BITS-1:0]  vec_z;
   } req_type;

   typedef struct packed {
      logic signed [VEC_BITS-1:0] out_x;
      logic signed [VEC_BITS-1:0] out_y;
      logic signed [VEC_BITS-1:0] out_z;
      logic                       saturated;
   } rsp_type;

   typedef logic signed [COEF_BITS-1:0] coef_type;
   typedef coef_type [AXES-1:0]         row_type;
   typedef logic signed [VEC_BITS-1:0]  vec_type;
   typedef vec_type [AXES-1:0]          vec3_type;

   typedef struct packed {
      logic signed [VEC_BITS-1:0] value;
      logic                       sat;
   } lane_res_type;

endpackage

[design/quaternion_vector_rotate.sv]
// Top level: matrix stage, three row lanes and the merging output stage.
// Rotates a vector into the other frame with a scalar-first unit quaternion
// (passive form). The block is a six-stage pipeline that takes one item on
// every clock cycle: busy is always low, so an item is accepted whenever start
// is high. Its result appears on rsp_data with rsp_valid high for one cycle,
// in order; the receiver cannot stall and must take it then. Two stages build
// the rotation matrix, three parallel row lanes each spend three stages on
// multiply, rounded sum and saturation, and a final stage merges the lanes
// and ORs their clip flags into saturated.
module quaternion_vector_rotate (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  qvr_pkg::req_type req_data,
   output logic             rsp_valid,
   output qvr_pkg::rsp_type rsp_data
);
   import qvr_pkg::*;

   row_type [LANES-1:0] mat;
   vec3_type            vec;
   lane_res_type        lane_res [LANES];
   logic [LATENCY-1:0]  vld_in, vld_ff;
   rsp_type             rsp_in, rsp_ff;

   // The pipeline never stalls
   assign busy = 1'b0;

   qvr_dcm u_dcm (
      .clock (clock),
      .req   (req_data),
      .mat   (mat),
      .vec   (vec)
   );

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      qvr_lane u_lane (
         .clock (clock),
         .row   (mat[i]),
         .vec   (vec),
         .res   (lane_res[i])
      );
   end

   // Merge the lanes into one result item
   always_comb begin
      rsp_in.out_x     = lane_res[0].value;
      rsp_in.out_y     = lane_res[1].value;
      rsp_in.out_z     = lane_res[2].value;
      rsp_in.saturated = lane_res[0].sat | lane_res[1].sat | lane_res[2].sat;
   end

   // Track which pipeline slots hold an item
   assign vld_in = {vld_ff[LATENCY-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = vld_ff[LATENCY-1];
   assign rsp_data  = rsp_ff;

endmodule

[design/qvr_dcm.sv]
// Pairwise quaternion products and direction cosine matrix, two register stages.
module qvr_dcm (
   input  logic                                   clock,
   input  qvr_pkg::req_type                       req,
   output qvr_pkg::row_type [qvr_pkg::LANES-1:0]  mat,
   output qvr_pkg::vec3_type                      vec
);
   import qvr_pkg::*;

   logic signed [PROD_BITS-1:0] ww_in, xx_in, yy_in, zz_in, wx_in, wy_in, wz_in;
   logic signed [PROD_BITS-1:0] xy_in, xz_in, yz_in;
   logic signed [PROD_BITS-1:0] ww_ff, xx_ff, yy_ff, zz_ff, wx_ff, wy_ff, wz_ff;
   logic signed [PROD_BITS-1:0] xy_ff, xz_ff, yz_ff;
   vec3_type                    vec1_in, vec1_ff, vec2_ff;
   row_type [LANES-1:0]         mat_in, mat_ff;

   // Form the ten pairwise products
   always_comb begin
      ww_in = PROD_BITS'(req.q_w * req.q_w);
      xx_in = PROD_BITS'(req.q_x * req.q_x);
      yy_in = PROD_BITS'(req.q_y * req.q_y);
      zz_in = PROD_BITS'(req.q_z * req.q_z);
      wx_in = PROD_BITS'(req.q_w * req.q_x);
      wy_in = PROD_BITS'(req.q_w * req.q_y);
      wz_in = PROD_BITS'(req.q_w * req.q_z);
      xy_in = PROD_BITS'(req.q_x * req.q_y);
      xz_in = PROD_BITS'(req.q_x * req.q_z);
      yz_in = PROD_BITS'(req.q_y * req.q_z);
      vec1_in[0] = req.vec_x;
      vec1_in[1] = req.vec_y;
      vec1_in[2] = req.vec_z;
   end

   // Combine products into the passive rotation matrix, exact in COEF_BITS
   always_comb begin
      coef_type ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
      ww = COEF_BITS'(ww_ff);
      xx = COEF_BITS'(xx_ff);
      yy = COEF_BITS'(yy_ff);
      zz = COEF_BITS'(zz_ff);
      wx = COEF_BITS'(wx_ff);
      wy = COEF_BITS'(wy_ff);
      wz = COEF_BITS'(wz_ff);
      xy = COEF_BITS'(xy_ff);
      xz = COEF_BITS'(xz_ff);
      yz = COEF_BITS'(yz_ff);
      mat_in[0][0] = ww + xx - yy - zz;
      mat_in[0][1] = (xy + wz) <<< 1;
      mat_in[0][2] = (xz - wy) <<< 1;
      mat_in[1][0] = (xy - wz) <<< 1;
      mat_in[1][1] = ww - xx + yy - zz;
      mat_in[1][2] = (yz + wx) <<< 1;
      mat_in[2][0] = (xz + wy) <<< 1;
      mat_in[2][1] = (yz - wx) <<< 1;
      mat_in[2][2] = ww - xx - yy + zz;
   end

   // Advance both stages every cycle
   always_ff @(posedge clock) begin
      ww_ff   <= ww_in;
      xx_ff   <= xx_in;
      yy_ff   <= yy_in;
      zz_ff   <= zz_in;
      wx_ff   <= wx_in;
      wy_ff   <= wy_in;
      wz_ff   <= wz_in;
      xy_ff   <= xy_in;
      xz_ff   <= xz_in;
      yz_ff   <= yz_in;
      vec1_ff <= vec1_in;
      mat_ff  <= mat_in;
      vec2_ff <= vec1_ff;
   end

   assign mat = mat_ff;
   assign vec = vec2_ff;

endmodule

[design/qvr_lane.sv]
// One matrix row times the vector: multiply, sum with rounding, shift and saturate.
module qvr_lane (
   input  logic                  clock,
   input  qvr_pkg::row_type      row,
   input  qvr_pkg::vec3_type     vec,
   output qvr_pkg::lane_res_type res
);
   import qvr_pkg::*;

   logic signed [TERM_BITS-1:0] term_in [AXES];
   logic signed [TERM_BITS-1:0] term_ff [AXES];
   logic signed [SUM_BITS-1:0]  sum_in, sum_ff;
   logic signed [RES_BITS-1:0]  shifted;
   logic [RES_BITS-VEC_BITS:0]  top_bits;
   logic                        ovf;
   lane_res_type                res_in, res_ff;

   // Multiply each entry by its vector part
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         term_in[i] = TERM_BITS'(row[i]) * TERM_BITS'(vec[i]);
      end
   end

   // Sum the three terms and add half an output step
   always_comb begin
      sum_in = SUM_BITS'(term_ff[0]) + SUM_BITS'(term_ff[1]) + SUM_BITS'(term_ff[2])
             + (SUM_BITS'(1) <<< (SHIFT - 1));
   end

   // Drop the fraction and clip to the output range
   always_comb begin
      shifted  = sum_ff[SUM_BITS-1:SHIFT];
      top_bits = shifted[RES_BITS-1:VEC_BITS-1];
      ovf      = !((&top_bits) || !(|top_bits));
      res_in.sat = ovf;
      if (ovf) begin
         res_in.value = shifted[RES_BITS-1] ? {1'b1, {(VEC_BITS-1){1'b0}}}
                                            : {1'b0, {(VEC_BITS-1){1'b1}}};
      end else begin
         res_in.value = shifted[VEC_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      term_ff <= term_in;
      sum_ff  <= sum_in;
      res_ff  <= res_in;
   end

   assign res = res_ff;

endmodule
